/* hdl/ct_pkg.sv */
// shared types and constants for the columnar transposition block
`timescale 1ns / 1ps
package ct_pkg;

	localparam int MAX_FRAME = 64;
	localparam int BYTE_W    = 8;
	localparam int ADDR_W    = $clog2(MAX_FRAME);
	localparam int LEN_W     = $clog2(MAX_FRAME + 1);
	localparam int COL_W     = 7;
	localparam int IDX_W     = COL_W + 1;
	localparam int DIV_CNT_W = $clog2(LEN_W);
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = COL_W;

	localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION    = 1'd1;

	localparam logic DIR_ENCRYPT = 1'b0;
	localparam logic DIR_DECRYPT = 1'b1;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_DIV,
		ST_READ,
		ST_SEND
	} ct_state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_DIV,
		PH_FIN,
		PH_WALK
	} walk_phase_t;

	typedef struct packed {
		logic             start;
		logic             step;
		logic [LEN_W-1:0] n;
		logic [COL_W-1:0] cols;
		logic             dir;
	} walk_cmd_t;

	typedef struct packed {
		logic              ready;
		logic              last;
		logic [ADDR_W-1:0] addr;
	} walk_sts_t;

endpackage

/* hdl/ct_channels.sv */
// valid/ready channels for input bytes and permuted output bytes
`timescale 1ns / 1ps
interface ct_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source (output valid, output data_byte, output frame_end, input ready);
	modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

interface ct_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

/* hdl/columnar_transposition.sv */
// top level: frame buffer, sequencer and output register of the transposition block
//
// byte_ch takes one frame of bytes, one word per cycle, the final one with
// frame_end set. Up to 64 bytes are held; further bytes of the same frame are
// dropped, and frame_end still releases what is held.
// After the word with frame_end, byte_ch.ready stays low until the last
// permuted word has been taken from perm_ch. The column count (0 acts as 1)
// and the direction (0 encrypt, 1 decrypt) are sampled with that word.
// Sequence after frame_end is taken: restoring division for rows and long
// columns, rounding of the row count, the sequencer picking up the walk,
// then one memory read into the output register, after which the first
// permuted word is valid.
// Emission reads each byte from the frame memory into the output register
// and offers it on perm_ch; the next byte is read only after it is taken.
// A stall on perm_ch holds the output register and the walk where they are.
// out_last marks the final permuted word.
// Reset clears the sequencer and frame length and sets column count 2,
// direction encrypt; the frame memory is not cleared.
`timescale 1ns / 1ps
module columnar_transposition (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ct_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ct_pkg::CFG_W-1:0]      cfg_data,
	ct_in_if.sink                         byte_ch,
	ct_out_if.source                      perm_ch
);
	import ct_pkg::*;

	ct_state_t state_q, state_nxt;

	logic [COL_W-1:0]  column_count_q;
	logic              direction_q;
	logic [LEN_W-1:0]  frame_length_q;
	logic [BYTE_W-1:0] frame_mem [MAX_FRAME];
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	walk_cmd_t walk_cmd;
	walk_sts_t walk_sts;

	logic             in_take;
	logic             out_take;
	logic             not_full;
	logic             mem_wr;
	logic             mem_rd;
	logic [LEN_W-1:0] frame_length_nxt;

	assign in_take  = byte_ch.valid && byte_ch.ready;
	assign out_take = perm_ch.valid && perm_ch.ready;
	assign not_full = (frame_length_q < LEN_W'(MAX_FRAME));
	assign mem_wr   = in_take && not_full;
	assign frame_length_nxt = frame_length_q + {{(LEN_W-1){1'b0}}, not_full};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= COL_W'(2);
			direction_q    <= DIR_ENCRYPT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COLUMN_COUNT: column_count_q <= cfg_data[COL_W-1:0];
				CFG_DIRECTION:    direction_q    <= cfg_data[0];
				default:          column_count_q <= column_count_q;
			endcase
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_LOAD: if (in_take && byte_ch.frame_end) state_nxt = ST_DIV;
			ST_DIV:  if (walk_sts.ready) state_nxt = ST_READ;
			ST_READ: state_nxt = ST_SEND;
			ST_SEND: begin
				if (out_take) begin
					state_nxt = out_last_q ? ST_LOAD : ST_READ;
				end
			end
			default: state_nxt = ST_LOAD;
		endcase
	end

	always_comb begin
		byte_ch.ready = (state_q == ST_LOAD);
		perm_ch.valid = (state_q == ST_SEND);
		mem_rd        = (state_q == ST_READ);
		walk_cmd.start = in_take && byte_ch.frame_end;
		walk_cmd.step  = (state_q == ST_READ);
		walk_cmd.n     = frame_length_nxt;
		walk_cmd.cols  = (column_count_q == '0) ? COL_W'(1) : column_count_q;
		walk_cmd.dir   = direction_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			frame_length_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (in_take) begin
				frame_length_q <= frame_length_nxt;
			end else if (out_take && out_last_q) begin
				frame_length_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			frame_mem[frame_length_q[ADDR_W-1:0]] <= byte_ch.data_byte;
		end
		if (mem_rd) begin
			out_byte_q <= frame_mem[walk_sts.addr];
			out_last_q <= walk_sts.last;
		end
	end

	ct_walk u_walk (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (walk_cmd),
		.sts    (walk_sts)
	);

	assign perm_ch.out_byte = out_byte_q;
	assign perm_ch.out_last = out_last_q;

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(byte_ch.ready && perm_ch.valid))
		else $error("loading and emitting at once");

	a_frame_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && perm_ch.out_last) |=> (frame_length_q == '0) && (state_q == ST_LOAD))
		else $error("frame not cleared after last word");

	a_length_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frame_length_q <= LEN_W'(MAX_FRAME))
		else $error("frame length beyond buffer");

	a_read_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> walk_sts.ready)
		else $error("memory read before walk is set up");

endmodule

/* hdl/ct_walk.sv */
// address walker: shared adder for the row/column division and the permutation walk
`timescale 1ns / 1ps
module ct_walk (
	input  logic              clk,
	input  logic              arst_n,
	input  ct_pkg::walk_cmd_t cmd,
	output ct_pkg::walk_sts_t sts
);
	import ct_pkg::*;

	walk_phase_t phase_q, phase_nxt;

	logic [LEN_W-1:0]     n_q;
	logic [COL_W-1:0]     cols_q;
	logic                 dir_q;
	logic [COL_W-1:0]     rem_q;
	logic [LEN_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [LEN_W-1:0]     rows_q;
	logic [IDX_W-1:0]     idx_q;
	logic [COL_W-1:0]     col_q;
	logic [LEN_W-1:0]     row_q;
	logic [LEN_W-1:0]     k_q;

	logic [IDX_W-1:0] add_a, add_b;
	logic             add_cin;
	logic [IDX_W:0]   sum;
	logic [IDX_W-1:0] rem_sh;
	logic [LEN_W-1:0] col_len;
	logic [COL_W-1:0] col_inc;
	logic [LEN_W-1:0] row_inc;
	logic [LEN_W-1:0] k_inc;
	logic             div_last;
	logic             last;

	assign rem_sh  = {rem_q, quo_q[LEN_W-1]};
	assign col_inc = col_q + 1'b1;
	assign row_inc = row_q + 1'b1;
	assign k_inc   = k_q + 1'b1;
	assign last    = (k_inc == n_q);
	assign div_last = (div_cnt_q == DIV_CNT_W'(LEN_W - 1));

	// short columns lie past the remainder when the matrix is not full
	assign col_len = (rem_q == '0 || col_q < rem_q) ? rows_q : rows_q - 1'b1;

	// the one adder, shared by every phase
	always_comb begin
		add_a   = idx_q;
		add_b   = {1'b0, cols_q};
		add_cin = 1'b0;
		case (phase_q)
			PH_DIV: begin
				add_a   = rem_sh;
				add_b   = ~{1'b0, cols_q};
				add_cin = 1'b1;
			end
			PH_FIN: begin
				add_a   = {1'b0, quo_q};
				add_b   = '0;
				add_cin = (rem_q != '0);
			end
			PH_WALK: begin
				add_a = idx_q;
				if (dir_q == DIR_DECRYPT) begin
					add_b = {1'b0, col_len};
				end else begin
					add_b = {1'b0, cols_q};
				end
			end
			default: begin
				add_a   = idx_q;
				add_b   = {1'b0, cols_q};
				add_cin = 1'b0;
			end
		endcase
	end

	assign sum = {1'b0, add_a} + {1'b0, add_b} + {{IDX_W{1'b0}}, add_cin};

	always_comb begin
		phase_nxt = phase_q;
		case (phase_q)
			PH_IDLE: if (cmd.start) phase_nxt = PH_DIV;
			PH_DIV:  if (div_last) phase_nxt = PH_FIN;
			PH_FIN:  phase_nxt = PH_WALK;
			PH_WALK: begin
				if (cmd.start) begin
					phase_nxt = PH_DIV;
				end else if (cmd.step && last) begin
					phase_nxt = PH_IDLE;
				end
			end
			default: phase_nxt = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= '0;
			cols_q    <= '0;
			dir_q     <= DIR_ENCRYPT;
			rem_q     <= '0;
			quo_q     <= '0;
			div_cnt_q <= '0;
			rows_q    <= '0;
			idx_q     <= '0;
			col_q     <= '0;
			row_q     <= '0;
			k_q       <= '0;
		end else if (cmd.start) begin
			n_q       <= cmd.n;
			cols_q    <= cmd.cols;
			dir_q     <= cmd.dir;
			rem_q     <= '0;
			quo_q     <= cmd.n;
			div_cnt_q <= '0;
			idx_q     <= '0;
			col_q     <= '0;
			row_q     <= '0;
			k_q       <= '0;
		end else begin
			case (phase_q)
				PH_DIV: begin
					// restoring division, one quotient bit per cycle
					rem_q     <= sum[IDX_W] ? sum[COL_W-1:0] : rem_sh[COL_W-1:0];
					quo_q     <= {quo_q[LEN_W-2:0], sum[IDX_W]};
					div_cnt_q <= div_cnt_q + 1'b1;
				end
				PH_FIN: begin
					rows_q <= sum[LEN_W-1:0];
				end
				PH_WALK: begin
					if (cmd.step) begin
						k_q <= k_inc;
						if (dir_q == DIR_DECRYPT) begin
							if (col_inc == cols_q) begin
								col_q <= '0;
								row_q <= row_inc;
								idx_q <= {1'b0, row_inc};
							end else begin
								col_q <= col_inc;
								idx_q <= sum[IDX_W-1:0];
							end
						end else begin
							if (sum[IDX_W-1:0] < {1'b0, n_q}) begin
								idx_q <= sum[IDX_W-1:0];
							end else begin
								col_q <= col_inc;
								idx_q <= {1'b0, col_inc};
							end
						end
					end
				end
				default: begin
					div_cnt_q <= div_cnt_q;
				end
			endcase
		end
	end

	assign sts.ready = (phase_q == PH_WALK);
	assign sts.last  = last;
	assign sts.addr  = idx_q[ADDR_W-1:0];

	a_rem_below_cols: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WALK) |-> (rem_q < cols_q))
		else $error("division remainder not below column count");

	a_walk_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WALK) |-> (idx_q < {1'b0, n_q}))
		else $error("walk index outside the held frame");

	a_div_to_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FIN) |=> (phase_q == PH_WALK) || $past(cmd.start))
		else $error("division finish not followed by walk");

endmodule
